### rtl/core/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types for the keyed count table: operation codes and the command
// bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int KEY_W    = 32;
   localparam int AMOUNT_W = 31;
   localparam int COUNT_W  = 32;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef struct packed {
      logic load;    // capture the request fields
      logic lookup;  // register key match and free slot
      logic commit;  // apply the update and load the result register
   } cmd_type;

endpackage

### rtl/core/kct_req_if.sv
// ----------------------------------------------------------------------------
// kct_req_if
// Request channel of the keyed count table: valid/ready plus one operation.
// ----------------------------------------------------------------------------
interface kct_req_if;
   import kct_pkg::*;

   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [KEY_W-1:0]    item_key;
   logic [AMOUNT_W-1:0] amount;
   logic                item_known;

   modport source (output valid, output mode, output item_key, output amount,
                   output item_known, input ready);
   modport sink   (input valid, input mode, input item_key, input amount,
                   input item_known, output ready);
endinterface

### rtl/core/kct_rsp_if.sv
// ----------------------------------------------------------------------------
// kct_rsp_if
// Response channel of the keyed count table: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface kct_rsp_if;
   import kct_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COUNT_W-1:0] result_value;
   logic                      table_full;

   modport source (output valid, output result_value, output table_full,
                   input ready);
   modport sink   (input valid, input result_value, input table_full,
                   output ready);
endinterface

### rtl/core/keyed_count_table.sv
// ----------------------------------------------------------------------------
// keyed_count_table
// Table of SLOTS item keys with a 32-bit count each; add, remove, clear all
// and query operations, one result per request.
// ----------------------------------------------------------------------------
// Each request has a lookup state, then an update state: lookup compares the
// key against every slot in parallel and registers the lowest matching and
// lowest free slot; update reads the chosen count, does the add or subtract
// and writes the slot. The result sits in an output register, so a new request
// is accepted in the update cycle of the previous one as long as that register
// is free or draining; a stalled response holds the block in the update cycle.
// Slot valid bits clear at once on reset, so no clearing pass is needed.
// Clear reports the entry count from a running occupancy counter.
module keyed_count_table #(
   parameter int SLOTS = 16
) (
   input  logic           clock,
   input  logic           reset,
   kct_req_if.sink        req_ch,
   kct_rsp_if.source      rsp_ch
);
   import kct_pkg::*;

   cmd_type cmd;

   kct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   kct_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_ch.mode),
      .req_item_key     (req_ch.item_key),
      .req_amount       (req_ch.amount),
      .req_item_known   (req_ch.item_known),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_table_full   (rsp_ch.table_full)
   );

endmodule

### rtl/core/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// Sequencer for the keyed count table: accept, lookup, update, and the
// response valid flag.
// ----------------------------------------------------------------------------
module kct_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kct_pkg::cmd_type cmd
);
   import kct_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      commit;
   logic      load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_UPDATE) && out_free;
   // a new request may enter on the cycle the previous one commits
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign load      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (load)        state_in = ST_LOOKUP;
            else if (commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = load;
   assign cmd.lookup = (state_ff == ST_LOOKUP);
   assign cmd.commit = commit;

endmodule

### rtl/core/kct_dp.sv
// ----------------------------------------------------------------------------
// kct_dp
// Datapath of the keyed count table: slot registers, parallel key match,
// count arithmetic, occupancy counter and result register.
// ----------------------------------------------------------------------------
module kct_dp #(
   parameter int SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kct_pkg::cmd_type                   cmd,
   input  kct_pkg::mode_type                  req_mode,
   input  logic [kct_pkg::KEY_W-1:0]          req_item_key,
   input  logic [kct_pkg::AMOUNT_W-1:0]       req_amount,
   input  logic                               req_item_known,
   output logic signed [kct_pkg::COUNT_W-1:0] rsp_result_value,
   output logic                               rsp_table_full
);
   import kct_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int OCC_W = $clog2(SLOTS + 1);

   // slot table
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [KEY_W-1:0]   slot_key_ff   [SLOTS];
   logic [COUNT_W-1:0] slot_count_ff [SLOTS];
   logic [OCC_W-1:0]   occ_ff, occ_in;

   // captured request
   mode_type            mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [AMOUNT_W-1:0] amount_ff;
   logic                known_ff;

   // lookup results
   logic [SLOTS-1:0] match_vec;
   logic             hit_in, hit_ff;
   logic [IDX_W-1:0] hit_idx_in, hit_idx_ff;
   logic             free_in, free_ff;
   logic [IDX_W-1:0] free_idx_in, free_idx_ff;

   // update
   logic [COUNT_W-1:0] cur_count;
   logic [COUNT_W-1:0] amt_ext;
   logic [COUNT_W-1:0] sum;
   logic [COUNT_W-1:0] diff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [COUNT_W-1:0] wr_count;
   logic               wr_key;
   logic [COUNT_W-1:0] result_in;
   logic               full_in;
   logic [COUNT_W-1:0] result_ff;
   logic               full_ff;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = valid_ff[i] && (slot_key_ff[i] == key_ff);
      end
      hit_in      = |match_vec;
      free_in     = ~&valid_ff;
      hit_idx_in  = '0;
      free_idx_in = '0;
      // scan down so the lowest index wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) hit_idx_in  = IDX_W'(i);
         if (!valid_ff[i]) free_idx_in = IDX_W'(i);
      end
   end

   assign cur_count = slot_count_ff[hit_idx_ff];
   assign amt_ext   = {1'b0, amount_ff};
   assign sum       = cur_count + amt_ext;
   // a missing key acts as a count of zero
   assign diff      = (hit_ff ? cur_count : '0) - amt_ext;

   always_comb begin
      valid_in  = valid_ff;
      occ_in    = occ_ff;
      wr_en     = 1'b0;
      wr_key    = 1'b0;
      wr_idx    = hit_idx_ff;
      wr_count  = sum;
      result_in = '0;
      full_in   = 1'b0;
      unique case (mode_ff)
         MODE_ADD: begin
            if (known_ff) begin
               if (hit_ff) begin
                  wr_en     = 1'b1;
                  wr_count  = sum;
                  result_in = sum;
               end else if (free_ff) begin
                  wr_en            = 1'b1;
                  wr_key           = 1'b1;
                  wr_idx           = free_idx_ff;
                  wr_count         = amt_ext;
                  valid_in[free_idx_ff] = 1'b1;
                  occ_in           = occ_ff + 1'b1;
                  result_in        = amt_ext;
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         MODE_REMOVE: begin
            result_in = diff;
            if (hit_ff && (cur_count > amt_ext)) begin
               wr_en    = 1'b1;
               wr_count = diff;
            end else if (hit_ff && (cur_count == amt_ext)) begin
               valid_in[hit_idx_ff] = 1'b0;
               occ_in               = occ_ff - 1'b1;
            end
         end
         MODE_CLEAR: begin
            valid_in  = '0;
            occ_in    = '0;
            result_in = COUNT_W'(occ_ff);
         end
         MODE_QUERY: begin
            result_in = hit_ff ? cur_count : '0;
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         key_ff    <= req_item_key;
         amount_ff <= req_amount;
         known_ff  <= req_item_known;
      end
      if (cmd.lookup) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         free_ff     <= free_in;
         free_idx_ff <= free_idx_in;
      end
      if (cmd.commit) begin
         result_ff <= result_in;
         full_ff   <= full_in;
         if (wr_en) begin
            slot_count_ff[wr_idx] <= wr_count;
         end
         if (wr_key) begin
            slot_key_ff[wr_idx] <= key_ff;
         end
      end
   end

   assign rsp_result_value = signed'(result_ff);
   assign rsp_table_full   = full_ff;

endmodule

### dv/tb_keyed_count_table.sv
// ----------------------------------------------------------------------------
// tb_keyed_count_table
// Self-checking bench for the keyed count table. A directed opening covers
// wrap, shortfall, exact removal, full table and clear. It is followed by
// random traffic on a small key pool, so that entries are hit, filled and
// freed often. A shadow table predicts each result at request transfer, and
// every response transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_keyed_count_table;
   import kct_pkg::*;

   localparam int TABLE_SLOTS  = 16;
   localparam int RANDOM_OPS   = 1900;
   localparam int KEY_POOL     = 20;
   localparam int CALM_TAIL    = 250;
   localparam int LONG_HOLD_AT = 500;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   // view 0 tracks accepted requests, view 1 runs ahead while generating
   localparam int VIEW_CHECK = 0;
   localparam int VIEW_GEN   = 1;

   typedef struct packed {
      logic                pause;   // hold the sender until all results are in
      mode_type            mode;
      logic [KEY_W-1:0]    key;
      logic [AMOUNT_W-1:0] amount;
      logic                known;
   } table_op_type;

   typedef struct packed {
      logic [COUNT_W-1:0] value;
      logic               full;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset;

   kct_req_if req_ch ();
   kct_rsp_if rsp_ch ();

   keyed_count_table #(
      .SLOTS (TABLE_SLOTS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow tables
   bit               slot_used [2][TABLE_SLOTS];
   bit [KEY_W-1:0]   slot_key  [2][TABLE_SLOTS];
   bit [COUNT_W-1:0] slot_cnt  [2][TABLE_SLOTS];

   table_op_type  pending_ops [$];
   table_rsp_type expected_rsp [$];

   table_op_type cur_op;
   logic         send_next;
   int unsigned  send_gap;
   int unsigned  send_idle_pct;
   int unsigned  recv_stall;
   int unsigned  recv_idle_pct;
   int unsigned  long_hold_left;
   logic         ready_next;
   int unsigned  ops_queued;
   int unsigned  ops_accepted;
   int unsigned  rsp_seen;
   int unsigned  mismatch_count;
   int unsigned  cycle_count;

   function automatic int find_key(input int view, input logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_used[view][i] && slot_key[view][i] == key) return i;
      end
      return -1;
   endfunction

   function automatic table_rsp_type table_update(input int view, input table_op_type op);
      table_rsp_type      r;
      int                 hit;
      int                 free_slot;
      logic [COUNT_W-1:0] amt;
      r         = '0;
      hit       = find_key(view, op.key);
      free_slot = -1;
      amt       = {1'b0, op.amount};
      case (op.mode)
         MODE_ADD: begin
            if (op.known) begin
               if (hit >= 0) begin
                  slot_cnt[view][hit] = slot_cnt[view][hit] + amt;
                  r.value = slot_cnt[view][hit];
               end else begin
                  for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
                     if (!slot_used[view][i]) free_slot = i;
                  end
                  if (free_slot >= 0) begin
                     slot_used[view][free_slot] = 1'b1;
                     slot_key[view][free_slot]  = op.key;
                     slot_cnt[view][free_slot]  = amt;
                     r.value = amt;
                  end else begin
                     r.full = 1'b1;
                  end
               end
            end
         end
         MODE_REMOVE: begin
            if (hit < 0) begin
               r.value = '0 - amt;
            end else if (slot_cnt[view][hit] > amt) begin
               slot_cnt[view][hit] = slot_cnt[view][hit] - amt;
               r.value = slot_cnt[view][hit];
            end else if (slot_cnt[view][hit] == amt) begin
               slot_used[view][hit] = 1'b0;
            end else begin
               r.value = slot_cnt[view][hit] - amt;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (slot_used[view][i]) r.value = r.value + 1;
               slot_used[view][i] = 1'b0;
            end
         end
         default: begin
            if (hit >= 0) r.value = slot_cnt[view][hit];
         end
      endcase
      return r;
   endfunction

   task automatic push_op(input mode_type mode, input logic [KEY_W-1:0] key,
                          input logic [AMOUNT_W-1:0] amount, input logic known);
      table_op_type op;
      op.pause  = 1'b0;
      op.mode   = mode;
      op.key    = key;
      op.amount = amount;
      op.known  = known;
      void'(table_update(VIEW_GEN, op));
      pending_ops.push_back(op);
      ops_queued++;
   endtask

   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 40;
      endcase
   endfunction

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         send_next = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(table_update(VIEW_CHECK, cur_op));
            ops_accepted++;
            if (ops_accepted % 128 == 0) send_idle_pct = pick_idle_pct();
            send_next = 1'b0;
         end
         if (!send_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_ops.size() > 0) begin
               if (pending_ops[0].pause) begin
                  if (expected_rsp.size() == 0) void'(pending_ops.pop_front());
               end else if (pending_ops.size() > CALM_TAIL &&
                            $urandom_range(0, 99) < send_idle_pct) begin
                  send_gap = $urandom_range(0, 18);
               end else begin
                  cur_op            = pending_ops.pop_front();
                  send_next         = 1'b1;
                  req_ch.mode       <= cur_op.mode;
                  req_ch.item_key   <= cur_op.key;
                  req_ch.amount     <= cur_op.amount;
                  req_ch.item_known <= cur_op.known;
               end
            end
         end
         req_ch.valid <= send_next;
      end
   end

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            table_rsp_type want;
            rsp_seen++;
            if (rsp_seen % 128 == 0) recv_idle_pct = pick_idle_pct();
            if (rsp_seen == LONG_HOLD_AT) long_hold_left = LONG_HOLD;
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transfer: result_value %0d table_full %0b",
                      rsp_ch.result_value, rsp_ch.table_full);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_ch.result_value !== want.value) begin
                  $error("result_value: expected %0d, got %0d",
                         $signed(want.value), rsp_ch.result_value);
                  mismatch_count++;
               end
               if (rsp_ch.table_full !== want.full) begin
                  $error("table_full: expected %0b, got %0b", want.full, rsp_ch.table_full);
                  mismatch_count++;
               end
            end
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            ready_next = 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            ready_next = 1'b0;
         end else if (pending_ops.size() > CALM_TAIL &&
                      $urandom_range(0, 99) < recv_idle_pct) begin
            recv_stall = $urandom_range(0, 18);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ch.ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("keyed_count_table verification failed");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0]    key_pool [KEY_POOL];
      logic [KEY_W-1:0]    key;
      logic [AMOUNT_W-1:0] amount;
      logic [COUNT_W-1:0]  near;
      mode_type            mode;
      table_op_type        pause_op;
      int                  hit;
      int unsigned         roll;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.mode       = MODE_QUERY;
      req_ch.item_key   = '0;
      req_ch.amount     = '0;
      req_ch.item_known = 1'b0;
      rsp_ch.ready      = 1'b0;
      send_gap          = 0;
      recv_stall        = 0;
      long_hold_left    = 0;
      send_idle_pct     = 10;
      recv_idle_pct     = 10;
      ops_queued        = 0;
      ops_accepted      = 0;
      rsp_seen          = 0;
      mismatch_count    = 0;
      cycle_count       = 0;
      pause_op          = '0;
      pause_op.pause    = 1'b1;

      // directed opening
      push_op(MODE_QUERY,  32'h0000_0000, '0, 1'b0);
      push_op(MODE_REMOVE, 32'hFFFF_FFFF, '1, 1'b1);     // missing key
      push_op(MODE_ADD,    32'hFFFF_FFFF, 31'd9, 1'b0);  // unknown item
      push_op(MODE_ADD,    32'hFFFF_FFFF, '1, 1'b1);     // new key
      push_op(MODE_ADD,    32'hFFFF_FFFF, '1, 1'b1);
      push_op(MODE_ADD,    32'hFFFF_FFFF, 31'd3, 1'b1);  // count wraps to 1
      push_op(MODE_REMOVE, 32'hFFFF_FFFF, '0, 1'b0);     // larger count
      push_op(MODE_REMOVE, 32'hFFFF_FFFF, 31'd2, 1'b1);  // shortfall
      for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
         push_op(MODE_ADD, 32'h1111_1111 * i, AMOUNT_W'(i), 1'b1);
      end
      push_op(MODE_ADD,    32'hDEAD_0001, 31'd7, 1'b1);  // table full
      push_op(MODE_REMOVE, 32'hFFFF_FFFF, 31'd1, 1'b1);  // exact count frees slot
      push_op(MODE_CLEAR,  '0, '0, 1'b0);

      // random traffic on a small key pool
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == RANDOM_OPS / 2) pending_ops.push_back(pause_op);
         key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                             : $urandom();
         roll = $urandom_range(0, 99);
         if (roll < 42)      mode = MODE_ADD;
         else if (roll < 72) mode = MODE_REMOVE;
         else if (roll < 98) mode = MODE_QUERY;
         else                mode = MODE_CLEAR;
         hit  = find_key(VIEW_GEN, key);
         roll = $urandom_range(0, 99);
         if (mode == MODE_REMOVE && hit >= 0 && roll < 60) begin
            // aim at the equal, one-less and one-more boundaries
            near = slot_cnt[VIEW_GEN][hit];
            case ($urandom_range(0, 2))
               0:       near = near;
               1:       near = near - 1;
               default: near = near + 1;
            endcase
            amount = near[COUNT_W-1] ? AMOUNT_W'($urandom()) : near[AMOUNT_W-1:0];
         end else if (roll < 70) begin
            amount = AMOUNT_W'($urandom_range(0, 15));
         end else if (roll < 90) begin
            amount = AMOUNT_W'($urandom());
         end else begin
            amount = $urandom_range(0, 1) ? '1 : '0;
         end
         push_op(mode, key, amount, $urandom_range(0, 9) != 0);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (rsp_seen < ops_queued)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("keyed_count_table verification clean");
      end else begin
         $display("keyed_count_table verification failed");
      end
      $finish;
   end

endmodule
